>>> rtl/core/sgmd_pkg.sv
// Package for the Sobel gradient core: shared types and constants.
// Used by the window front end, the gradient back end and the top level.
package sgmd_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned GradW = 11;  // signed gx, gy in [-1020, 1020]
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned CntRowW = 12;

  typedef enum logic [0:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DirHorizontal = 2'd0,
    DirVertical   = 2'd1,
    DirMinus45    = 2'd2,
    DirPlus45     = 2'd3
  } dir_e;

  // One window of gradients handed from the front end to the back end.
  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    last;
  } grad_item_t;

endpackage

>>> rtl/core/sobel_gradient_magnitude_direction_core.sv
// Sobel 3x3 gradient magnitude and direction core, top level.
// Throughput: pixels enter at one per cycle until the queue fills; interior
// results come from a bit-serial square root unit that takes a new item only
// when it has finished the last one.
// Reset: counters, window control and queue clear; width 1024, height 768.
module sobel_gradient_magnitude_direction_core import sgmd_pkg::*; #(
  parameter int unsigned MaxLine = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic [PixW-1:0]     pixel_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic [PixW-1:0]     magnitude_o,
  output logic [1:0]          direction_o,
  output logic                frame_last_o
);

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  f_valid, f_ready, b_valid, b_ready;
  grad_item_t            f_item, b_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthRegW'(1024);
      height_q <= HeightRegW'(768);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegImageWidth: width_q <= cfg_data_i[WidthRegW-1:0];
        RegImageHeight: height_q <= cfg_data_i[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  sgmd_front #(.MaxLine(MaxLine)) u_front (
    .clk_i, .rst_ni,
    .width_i(width_q), .height_i(height_q),
    .pix_valid_i(pixel_valid_i), .pix_ready_o(pixel_ready_o), .pixel_i,
    .item_valid_o(f_valid), .item_ready_i(f_ready), .item_o(f_item)
  );

  sgmd_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_item_i(f_item),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_item_o(b_item)
  );

  sgmd_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(b_valid), .item_ready_o(b_ready), .item_i(b_item),
    .res_valid_o(result_valid_o), .res_ready_i(result_ready_i),
    .magnitude_o, .direction_o, .frame_last_o
  );

endmodule

>>> rtl/core/sgmd_front.sv
// Front end: line stores, 3x3 window, position counters and gradient sums.
// Depends on sgmd_pkg. Emits one gradient item per interior pixel.
module sgmd_front import sgmd_pkg::*; #(
  parameter int unsigned MaxLine = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [WidthRegW-1:0]  width_i,
  input  logic [HeightRegW-1:0] height_i,
  input  logic                  pix_valid_i,
  output logic                  pix_ready_o,
  input  logic [PixW-1:0]       pixel_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output grad_item_t            item_o
);

  localparam int unsigned AddrW = (MaxLine > 1) ? $clog2(MaxLine) : 1;
  localparam int unsigned ColW = $clog2(MaxLine + 1);
  localparam int unsigned CmpW = ((ColW > WidthRegW) ? ColW : WidthRegW) + 1;

  // Line stores: a holds the row above, b two rows above.
  logic [PixW-1:0] store_a [MaxLine];
  logic [PixW-1:0] store_b [MaxLine];

  logic [ColW-1:0]    col_q, col_d;
  logic [CntRowW-1:0] row_q, row_d;
  logic [3*PixW-1:0]  win1_q, win2_q;
  logic               s1_valid_q;
  logic               s1_emit_q, s1_last_q;
  logic [PixW-1:0]    s1_pix_q, top_q, mid_q;
  logic               out_valid_q;
  grad_item_t         out_q;
  logic               accept, adv;
  logic [AddrW-1:0]   idx;
  logic [CmpW-1:0]    w_eff;
  logic [HeightRegW:0] h_eff;
  logic               col_end, row_end;

  // Clamp the configured sizes to the supported range.
  always_comb begin
    if (width_i < WidthRegW'(3)) w_eff = CmpW'(3);
    else if (CmpW'(width_i) > CmpW'(MaxLine)) w_eff = CmpW'(MaxLine);
    else w_eff = CmpW'(width_i);
    if (height_i < HeightRegW'(3)) h_eff = (HeightRegW+1)'(3);
    else if (height_i > HeightRegW'(MaxHeight)) h_eff = (HeightRegW+1)'(MaxHeight);
    else h_eff = (HeightRegW+1)'(height_i);
  end

  assign idx = (col_q < ColW'(MaxLine)) ? col_q[AddrW-1:0] : AddrW'(MaxLine - 1);
  assign col_end = (CmpW'(col_q) + CmpW'(1)) >= w_eff;
  assign row_end = ({2'b0, row_q} + (HeightRegW+1)'(1)) >= h_eff;

  // Two-stage flow: stage 1 reads the line stores, stage 2 forms the window.
  assign adv = !out_valid_q || item_ready_i;
  assign pix_ready_o = !s1_valid_q || adv;
  assign accept = pix_valid_i && pix_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CntRowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Line store access; read data is registered.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= store_b[idx];
      mid_q <= store_a[idx];
      store_a[idx] <= pixel_i;
      store_b[idx] <= store_a[idx];
      s1_pix_q <= pixel_i;
      s1_emit_q <= (row_q >= CntRowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= col_end && row_end;
    end
  end

  // Window shift and gradient sums.
  logic signed [GradW-1:0] gx_c, gy_c;
  always_comb begin
    logic signed [GradW-1:0] lt, lm, lb, ct, cb, rt, rm, rb;
    lt = GradW'(win1_q[7:0]);
    lm = GradW'(win1_q[15:8]);
    lb = GradW'(win1_q[23:16]);
    ct = GradW'(win2_q[7:0]);
    cb = GradW'(win2_q[23:16]);
    rt = GradW'(top_q);
    rm = GradW'(mid_q);
    rb = GradW'(s1_pix_q);
    gx_c = (lb - lt) + ((cb - ct) <<< 1) + (rb - rt);
    gy_c = (lt + (lm <<< 1) + lb) - (rt + (rm <<< 1) + rb);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && adv) begin
      win1_q <= win2_q;
      win2_q <= {s1_pix_q, mid_q, top_q};
      out_q.gx <= gx_c;
      out_q.gy <= gy_c;
      out_q.last <= s1_last_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) s1_valid_q <= 1'b1;
      else if (adv) s1_valid_q <= 1'b0;
      if (adv) out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  assign item_valid_o = out_valid_q;
  assign item_o = out_q;

endmodule

>>> rtl/core/sgmd_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on sgmd_pkg for the gradient item type.
module sgmd_queue import sgmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  grad_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output grad_item_t out_item_o
);

  grad_item_t   mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_item_o = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_item_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/sgmd_back.sv
// Back end: iterative integer square root and sector classification.
// Depends on sgmd_pkg. One bit of the root per cycle.
module sgmd_back import sgmd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  grad_item_t      item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [PixW-1:0] magnitude_o,
  output logic [1:0]      direction_o,
  output logic            frame_last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSquare,
    StRoot,
    StSector
  } state_e;

  state_e          state_q;
  logic [GradW-2:0] ax_q, ay_q;
  logic            gx_zero_q, same_sign_q, last_q;
  logic [20:0]     sq_q;          // gx^2 + gy^2, up to 2080800
  logic [PixW-1:0] root_q;
  logic [PixW-1:0] bit_q;
  logic            res_valid_q;
  logic [PixW-1:0] mag_q;
  logic [1:0]      dir_q;
  logic            flast_q;

  logic [PixW-1:0] trial;
  logic [2*PixW-1:0] trial_sq;
  logic [GradW-1:0] sum_a, diff_a;
  logic [21:0]     sum_sq, diff_sq, two_ax_sq;
  logic            is_h, is_v;
  logic [1:0]      dir_c;

  assign trial = root_q | bit_q;
  assign trial_sq = trial * trial;

  // Sector comparisons against tan(22.5) and tan(67.5).
  always_comb begin
    sum_a = {1'b0, ay_q} + {1'b0, ax_q};
    diff_a = {1'b0, ay_q} - {1'b0, ax_q};
    sum_sq = 22'(sum_a * sum_a);
    diff_sq = 22'(diff_a * diff_a);
    two_ax_sq = 22'({ax_q, 1'b0} * ax_q);
    is_h = sum_sq < two_ax_sq;
    is_v = (ay_q > ax_q) && (diff_sq > two_ax_sq);
    if (gx_zero_q) dir_c = DirVertical;
    else if (is_h) dir_c = DirHorizontal;
    else if (is_v) dir_c = DirVertical;
    else if (same_sign_q) dir_c = DirPlus45;
    else dir_c = DirMinus45;
  end

  assign item_ready_o = (state_q == StIdle);

  // Sequencer with registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i && state_q != StSector) res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            ax_q <= item_i.gx[GradW-1] ? (GradW-1)'(-item_i.gx) : (GradW-1)'(item_i.gx);
            ay_q <= item_i.gy[GradW-1] ? (GradW-1)'(-item_i.gy) : (GradW-1)'(item_i.gy);
            gx_zero_q <= item_i.gx == '0;
            same_sign_q <= item_i.gx[GradW-1] == item_i.gy[GradW-1];
            last_q <= item_i.last;
            state_q <= StSquare;
          end
        end
        StSquare: begin
          sq_q <= 21'(ax_q * ax_q) + 21'(ay_q * ay_q);
          root_q <= '0;
          bit_q <= 8'h80;
          state_q <= StRoot;
        end
        StRoot: begin
          if (21'(trial_sq) <= sq_q) root_q <= trial;
          bit_q <= bit_q >> 1;
          if (bit_q == 8'h01) state_q <= StSector;
        end
        StSector: begin
          if (!res_valid_q || res_ready_i) begin
            mag_q <= (sq_q >= 21'd65536) ? 8'hFF : root_q;
            dir_q <= dir_c;
            flast_q <= last_q;
            res_valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign magnitude_o = mag_q;
  assign direction_o = dir_q;
  assign frame_last_o = flast_q;

endmodule

>>> test/testbench.sv
// Testbench for the Sobel gradient magnitude and direction core.
// Streams whole frames of pixels, predicts each result in a local model of the
// window and line stores, and checks every result field. Depends on sgmd_pkg.
`timescale 1ns / 100ps

module testbench;
  import sgmd_pkg::*;

  localparam int LineMax = 1024;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [PixW-1:0] magnitude;
    dir_e            direction;
    logic            frame_last;
  } sobel_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                pixel_valid_i;
  logic                pixel_ready_o;
  logic [PixW-1:0]     pixel_i;
  logic                result_valid_o;
  logic                result_ready_i;
  logic [PixW-1:0]     magnitude_o;
  logic [1:0]          direction_o;
  logic                frame_last_o;

  sobel_gradient_magnitude_direction_core dut (.*);

  // Pixels waiting to be sent and results waiting to be seen.
  logic [PixW-1:0] pixel_queue[$];
  sobel_result_t   expected_results[$];
  int              error_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              cycle_count = 0;

  // Local copy of the block state.
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic [7:0]            row_above[LineMax];
  logic [7:0]            two_rows_above[LineMax];
  logic [23:0]           window[3];
  int                    col_pos;
  int                    row_pos;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] sqrt_floor_sat(longint s);
    int r;
    int b;
    r = 0;
    if (s >= 65536) return 8'd255;
    for (b = 128; b != 0; b = b >> 1) begin
      if (longint'(r + b) * (r + b) <= s) r = r + b;
    end
    return r[7:0];
  endfunction

  // Sector by exact comparison with tan 22.5 and tan 67.5.
  function automatic dir_e gradient_sector(int gx, int gy);
    longint ax;
    longint ay;
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    if (gx == 0) return DirVertical;
    if ((ay + ax) * (ay + ax) < 2 * ax * ax) return DirHorizontal;
    if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) return DirVertical;
    return ((gx < 0) == (gy < 0)) ? DirPlus45 : DirMinus45;
  endfunction

  function automatic int lane(logic [23:0] c, int k);
    return int'(c[8*k +: 8]);
  endfunction

  // Advance the window with one pixel and queue the result it causes.
  function automatic void predict_gradient(logic [7:0] p);
    int w;
    int h;
    int idx;
    int gx;
    int gy;
    logic [7:0] top;
    logic [7:0] mid;
    logic last;
    sobel_result_t r;
    w = clamp_int(int'(width_reg), 3, LineMax);
    h = clamp_int(int'(height_reg), 3, MaxHeight);
    idx = col_pos < LineMax ? col_pos : LineMax - 1;
    top = two_rows_above[idx];
    mid = row_above[idx];
    last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    two_rows_above[idx] = mid;
    row_above[idx] = p;
    window[0] = window[1];
    window[1] = window[2];
    window[2] = {p, mid, top};
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (lane(window[0], 2) - lane(window[0], 0))
         + 2 * (lane(window[1], 2) - lane(window[1], 0))
         + (lane(window[2], 2) - lane(window[2], 0));
      gy = (lane(window[0], 0) + 2 * lane(window[0], 1) + lane(window[0], 2))
         - (lane(window[2], 0) + 2 * lane(window[2], 1) + lane(window[2], 2));
      r.magnitude = sqrt_floor_sat(longint'(gx) * gx + longint'(gy) * gy);
      r.direction = gradient_sector(gx, gy);
      r.frame_last = last;
      expected_results = {expected_results, r};
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Pixel driver: holds the item until it is taken, predicts on acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
    end else begin
      if (pixel_valid_i && pixel_ready_o) predict_gradient(pixel_i);
      if (!pixel_valid_i || pixel_ready_o) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_valid_i <= 1'b1;
          pixel_i <= pixel_queue.pop_front();
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back pressure.
  always @(posedge clk_i) begin
    sobel_result_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", magnitude_o, -1);
      end else begin
        want = expected_results.pop_front();
        if (magnitude_o !== want.magnitude)
          report_mismatch("magnitude", magnitude_o, want.magnitude);
        if (direction_o !== want.direction)
          report_mismatch("direction", direction_o, want.direction);
        if (frame_last_o !== want.frame_last)
          report_mismatch("frame_last", frame_last_o, want.frame_last);
      end
    end
    result_ready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegImageWidth) width_reg = value[WidthRegW-1:0];
    else height_reg = value[HeightRegW-1:0];
  endtask

  // Wait until every pixel is taken and every result has come out.
  task automatic drain;
    while (pixel_queue.size() > 0 || pixel_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Queue one frame once the block is idle. Styles: 0 noise, 1 ramp,
  // 2 two-level, 3 constant.
  task automatic queue_frame(int w_val, int h_val, int style);
    int w;
    int h;
    int x;
    int y;
    int sx;
    int sy;
    int base;
    logic [7:0] v;
    w = clamp_int(w_val & 2047, 3, LineMax);
    h = clamp_int(h_val & 8191, 3, MaxHeight);
    drain();
    write_reg(RegImageWidth, w_val);
    write_reg(RegImageHeight, h_val);
    sx = int'($urandom_range(80)) - 40;
    sy = int'($urandom_range(80)) - 40;
    base = int'($urandom_range(255));
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        case (style)
          0: v = 8'($urandom_range(255));
          1: v = 8'(clamp_int(base + sx * x + sy * y + int'($urandom_range(6)), 0, 255));
          2: v = $urandom_range(1) ? 8'hFF : 8'h00;
          default: v = base[7:0];
        endcase
        pixel_queue = {pixel_queue, v};
      end
    end
  endtask

  initial begin
    int ph;
    int sent;
    int w;
    int h;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegImageWidth;
    cfg_data_i = '0;
    pixel_valid_i = 1'b0;
    pixel_i = '0;
    result_ready_i = 1'b0;
    width_reg = 11'd1024;
    height_reg = 13'd768;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < LineMax; i++) begin
      row_above[i] = '0;
      two_rows_above[i] = '0;
    end
    for (int i = 0; i < 3; i++) window[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: a step edge, a flat frame, a two-level frame at clamped sizes.
    write_reg(RegImageWidth, 4);
    write_reg(RegImageHeight, 4);
    for (int i = 0; i < 16; i++) pixel_queue = {pixel_queue, ((i % 4) < 2 ? 8'h00 : 8'hFF)};
    drain();
    queue_frame(3, 3, 3);
    drain();
    queue_frame(0, 1, 2);
    drain();

    // Random frames under each idling mode.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      sent = 0;
      while (sent < 400) begin
        w = $urandom_range(12, 3);
        h = $urandom_range(9, 3);
        queue_frame(w, h, $urandom_range(3) == 3 ? 2 : $urandom_range(1));
        sent += w * h;
        if ($urandom_range(3) == 0) drain();
      end
      drain();
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sgmd_pkg.sv
rtl/core/sgmd_front.sv
rtl/core/sgmd_queue.sv
rtl/core/sgmd_back.sv
rtl/core/sobel_gradient_magnitude_direction_core.sv
test/testbench.sv
